FILE: rtl/slsmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsmp_pkg
// Shared types, register indexes, stage map and step functions for the spot
// light sample pipeline.
// ----------------------------------------------------------------------------
package slsmp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_OUTER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COS_INNER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 3'd6;

    localparam logic [47:0] AXIS_RST      = 48'h0000_4000_0000;
    localparam logic [15:0] COS_OUTER_RST = 16'h0000;
    localparam logic [15:0] COS_INNER_RST = 16'h4000;

    // falloff classes
    localparam logic [1:0] WCLS_ZERO = 2'd0;
    localparam logic [1:0] WCLS_BAND = 2'd1;
    localparam logic [1:0] WCLS_FULL = 2'd2;

    localparam logic [14:0] DIR_ONE = 15'd16384;

    // back-end stage map
    localparam int RT_N    = 32;
    localparam int DV_N    = 15;
    localparam int FR_N    = 16;
    localparam int RD_N    = 32;
    localparam int ST_SQ   = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_RT   = 2;
    localparam int ST_DN   = ST_RT + RT_N;
    localparam int ST_DV   = ST_DN + 1;
    localparam int ST_DIR  = ST_DV + DV_N;
    localparam int ST_COS  = ST_DIR + 1;
    localparam int ST_FR   = ST_COS + 1;
    localparam int ST_FF   = ST_FR + FR_N;
    localparam int ST_F2   = ST_FF + 1;
    localparam int ST_W    = ST_F2 + 1;
    localparam int ST_IW   = ST_W + 1;
    localparam int ST_RN   = ST_IW + 1;
    localparam int ST_RD   = ST_RN + 1;
    localparam int NSTG    = ST_RD + RD_N;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             shr;
        logic             degen;
    } t_item;

    typedef struct packed {
        logic [47:0] axis;
        logic [15:0] cos_outer;
        logic [15:0] cos_inner;
        logic [47:0] intensity;
    } t_cfg;

    typedef struct packed {
        logic [2:0][15:0] dir;
        logic [2:0][31:0] rad;
        logic             degen;
    } t_res;

    typedef struct packed {
        t_item            it;
        logic [2:0][63:0] sq;
        logic [63:0]      d2;
        logic [63:0]      rt_rem;
        logic [31:0]      rt_q;
        logic [2:0][46:0] dv_rem;
        logic [2:0][14:0] dv_q;
        logic [2:0][15:0] dir;
        logic [2:0][31:0] prod;
        logic [1:0]       wcls;
        logic [31:0]      fr_rem;
        logic [31:0]      fr_den;
        logic [15:0]      fr_q;
        logic [31:0]      ff;
        logic [16:0]      w;
        logic [2:0][32:0] iw;
        logic [2:0][63:0] rd_rem;
        logic [2:0][31:0] rd_lo;
        logic [2:0][31:0] rd_q;
        logic [2:0]       sat;
    } t_bk;

    // one root bit, rem = v - q*q
    function automatic logic [95:0] sqrt_step(input logic [63:0] rem, input logic [31:0] q,
                                              input int k);
        logic [65:0] trial;
        logic [63:0] nrem;
        logic [31:0] nq;
        trial = ({34'd0, q} << (k + 1)) + (66'd1 << (2 * k));
        nrem  = rem;
        nq    = q;
        if ({2'b00, rem} >= trial) begin
            nrem = rem - trial[63:0];
            nq   = q | (32'd1 << k);
        end
        return {nrem, nq};
    endfunction

    // one quotient bit of the direction divide
    function automatic logic [61:0] div_step(input logic [46:0] rem, input logic [14:0] q,
                                             input logic [31:0] den, input int k);
        logic [46:0] dvs;
        logic [46:0] nrem;
        logic [14:0] nq;
        dvs  = {15'd0, den} << k;
        nrem = rem;
        nq   = q;
        if (rem >= dvs) begin
            nrem = rem - dvs;
            nq   = q | (15'd1 << k);
        end
        return {nrem, nq};
    endfunction

    // one fraction bit, rem < den on entry
    function automatic logic [47:0] frac_step(input logic [31:0] rem, input logic [15:0] q,
                                              input logic [31:0] den);
        logic [31:0] rem2;
        rem2 = {rem[30:0], 1'b0};
        if (rem2 >= den) begin
            return {rem2 - den, q[14:0], 1'b1};
        end
        return {rem2, q[14:0], 1'b0};
    endfunction

    // one radiance quotient bit, low numerator bits fed msb first
    function automatic logic [127:0] rad_step(input logic [63:0] rem, input logic [31:0] lo,
                                              input logic [31:0] q, input logic [63:0] d2);
        logic [64:0] rem2;
        logic [64:0] diff;
        rem2 = {rem, lo[31]};
        diff = rem2 - {1'b0, d2};
        if (rem2 >= {1'b0, d2}) begin
            return {diff[63:0], lo[30:0], 1'b0, q[30:0], 1'b1};
        end
        return {rem2[63:0], lo[30:0], 1'b0, q[30:0], 1'b0};
    endfunction

endpackage

FILE: rtl/slsmp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsmp_front
// Takes a shading point, forms the offset to the light, its magnitudes,
// the range shift and the coincident-point flag.
// ----------------------------------------------------------------------------
module slsmp_front
    import slsmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0][31:0] i_eye,
    input  logic [2:0][31:0] i_lp,
    input  logic             i_qfull,
    output logic             o_busy,
    output logic             o_push,
    output t_item            o_item
);

    logic            r_vld;
    t_item           r_item;
    logic            n_vld;
    t_item           n_item;
    logic            ready;
    logic [32:0]     d   [3];
    logic [32:0]     m33 [3];
    logic            any_big;
    logic            all_zero;

    assign ready  = !r_vld || !i_qfull;
    assign o_busy = !ready;
    assign o_push = r_vld && !i_qfull;
    assign o_item = r_item;

    always_comb begin
        any_big  = 1'b0;
        all_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
            d[i]   = {i_lp[i][31], i_lp[i]} - {i_eye[i][31], i_eye[i]};
            m33[i] = d[i][32] ? (33'd0 - d[i]) : d[i];
            any_big  = any_big | m33[i][32] | m33[i][31];
            all_zero = all_zero & (d[i] == 33'd0);
        end
        for (int i = 0; i < 3; i++) begin
            n_item.mag[i] = any_big ? m33[i][32:1] : m33[i][31:0];
            n_item.neg[i] = d[i][32];
        end
        n_item.shr   = any_big;
        n_item.degen = all_zero;
    end

    always_comb begin
        n_vld = r_vld;
        if (i_start && ready) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && ready) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/slsmp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsmp_queue
// Two-entry queue between front and back; the back end drains it every
// cycle that it holds a request.
// ----------------------------------------------------------------------------
module slsmp_queue
    import slsmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_vld,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign pop    = o_vld;
    assign o_item = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: rtl/slsmp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsmp_back
// Arithmetic pipeline: squared distance, root, direction divides, cone
// falloff and radiance divides, one bit per stage in each iterative part.
// ----------------------------------------------------------------------------
module slsmp_back
    import slsmp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vld,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_res_vld,
    output t_res  o_res
);

    t_bk             r_pipe [NSTG];
    logic [NSTG-1:0] r_vld;
    logic            r_res_vld;
    t_res            r_res;
    t_res            n_res;

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        t_bk n_stg;
        if (g == ST_SQ) begin : g_sq
            always_comb begin
                n_stg    = '0;
                n_stg.it = i_item;
                for (int i = 0; i < 3; i++) begin
                    n_stg.sq[i] = {32'd0, i_item.mag[i]} * {32'd0, i_item.mag[i]};
                end
            end
        end else begin : g_op
            t_bk p;
            assign p = r_pipe[g-1];
            if (g == ST_SUM) begin : g_sum
                always_comb begin
                    n_stg        = p;
                    n_stg.d2     = p.sq[0] + p.sq[1] + p.sq[2];
                    n_stg.rt_rem = p.sq[0] + p.sq[1] + p.sq[2];
                    n_stg.rt_q   = '0;
                end
            end else if (g < ST_DN) begin : g_rt
                localparam int K = RT_N - 1 - (g - ST_RT);
                always_comb begin
                    n_stg = p;
                    {n_stg.rt_rem, n_stg.rt_q} = sqrt_step(p.rt_rem, p.rt_q, K);
                end
            end else if (g == ST_DN) begin : g_dn
                // mag * 2^14 + len / 2, rounds the quotient half up
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        n_stg.dv_rem[i] = {1'b0, p.it.mag[i], 14'd0} + {16'd0, p.rt_q[31:1]};
                        n_stg.dv_q[i]   = '0;
                    end
                end
            end else if (g < ST_DIR) begin : g_dv
                localparam int K = DV_N - 1 - (g - ST_DV);
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        {n_stg.dv_rem[i], n_stg.dv_q[i]} =
                            div_step(p.dv_rem[i], p.dv_q[i], p.rt_q, K);
                    end
                end
            end else if (g == ST_DIR) begin : g_dir
                logic [14:0]        qc  [3];
                logic signed [15:0] dsg [3];
                logic signed [15:0] ax  [3];
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        qc[i]  = (p.dv_q[i] > DIR_ONE) ? DIR_ONE : p.dv_q[i];
                        dsg[i] = p.it.neg[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
                        ax[i]  = $signed(i_cfg.axis[16*i +: 16]);
                        n_stg.dir[i]  = dsg[i];
                        n_stg.prod[i] = dsg[i] * ax[i];
                    end
                end
            end else if (g == ST_COS) begin : g_cos
                logic signed [33:0] sum;
                logic signed [33:0] c;
                logic signed [33:0] o28;
                logic signed [33:0] i28;
                logic signed [33:0] num;
                logic signed [33:0] den;
                always_comb begin
                    n_stg = p;
                    sum = $signed({{2{p.prod[0][31]}}, p.prod[0]})
                        + $signed({{2{p.prod[1][31]}}, p.prod[1]})
                        + $signed({{2{p.prod[2][31]}}, p.prod[2]});
                    c   = -sum;
                    o28 = $signed({{4{i_cfg.cos_outer[15]}}, i_cfg.cos_outer, 14'd0});
                    i28 = $signed({{4{i_cfg.cos_inner[15]}}, i_cfg.cos_inner, 14'd0});
                    num = c - o28;
                    den = i28 - o28;
                    if (c < o28) begin
                        n_stg.wcls = WCLS_ZERO;
                    end else if (c < i28) begin
                        n_stg.wcls = WCLS_BAND;
                    end else begin
                        n_stg.wcls = WCLS_FULL;
                    end
                    n_stg.fr_rem = num[31:0];
                    n_stg.fr_den = den[31:0];
                    n_stg.fr_q   = '0;
                end
            end else if (g < ST_FF) begin : g_fr
                always_comb begin
                    n_stg = p;
                    {n_stg.fr_rem, n_stg.fr_q} = frac_step(p.fr_rem, p.fr_q, p.fr_den);
                end
            end else if (g == ST_FF) begin : g_ff
                always_comb begin
                    n_stg    = p;
                    n_stg.ff = {16'd0, p.fr_q} * {16'd0, p.fr_q};
                end
            end else if (g == ST_F2) begin : g_f2
                logic [32:0] rnd;
                always_comb begin
                    n_stg    = p;
                    rnd      = {1'b0, p.ff} + 33'd32768;
                    n_stg.ff = {16'd0, rnd[31:16]} * {16'd0, rnd[31:16]};
                end
            end else if (g == ST_W) begin : g_w
                logic [32:0] rnd;
                always_comb begin
                    n_stg = p;
                    rnd   = {1'b0, p.ff} + 33'd32768;
                    case (p.wcls)
                        WCLS_BAND: n_stg.w = {1'b0, rnd[31:16]};
                        WCLS_FULL: n_stg.w = 17'h10000;
                        default:   n_stg.w = '0;
                    endcase
                end
            end else if (g == ST_IW) begin : g_iw
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        n_stg.iw[i] = {17'd0, i_cfg.intensity[16*i +: 16]} * {16'd0, p.w};
                    end
                end
            end else if (g == ST_RN) begin : g_rn
                logic [56:0] num [3];
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        num[i] = p.it.shr ? {2'b00, p.iw[i], 22'd0} : {p.iw[i], 24'd0};
                        n_stg.rd_rem[i] = {39'd0, num[i][56:32]};
                        n_stg.rd_lo[i]  = num[i][31:0];
                        n_stg.rd_q[i]   = '0;
                        // quotient would not fit in 32 bits
                        n_stg.sat[i]    = ({39'd0, num[i][56:32]} >= p.d2);
                    end
                end
            end else begin : g_rd
                always_comb begin
                    n_stg = p;
                    for (int i = 0; i < 3; i++) begin
                        {n_stg.rd_rem[i], n_stg.rd_lo[i], n_stg.rd_q[i]} =
                            rad_step(p.rd_rem[i], p.rd_lo[i], p.rd_q[i], p.d2);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_pipe[g] <= n_stg;
        end
    end

    always_comb begin
        n_res.degen = r_pipe[NSTG-1].it.degen;
        for (int i = 0; i < 3; i++) begin
            if (r_pipe[NSTG-1].it.degen) begin
                n_res.dir[i] = '0;
                n_res.rad[i] = '0;
            end else begin
                n_res.dir[i] = r_pipe[NSTG-1].dir[i];
                n_res.rad[i] = r_pipe[NSTG-1].sat[i] ? 32'hFFFF_FFFF : r_pipe[NSTG-1].rd_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[NSTG-2:0], i_vld};
            r_res_vld <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

FILE: rtl/spot_light_sample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_light_sample
// Spot light evaluation at a shading point: direction to the light, pdf and
// fourth-power-falloff inverse-square radiance per color channel.
// ----------------------------------------------------------------------------
//  channel   handshake                     payload
//  request   start & !busy                 i_eye_x/y/z
//  result    o_result_strobe (no stall)    o_dir_*, o_radiance_*, o_sample_pdf,
//                                          o_degenerate
//  config    i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
//  one request per clock sustained
//  the pipeline holds a 32-stage root, 15-stage direction divide, 16-stage
//  fraction divide and 32-stage radiance divide, one bit per stage
//  synchronous active-low reset clears the pipeline valids and loads register defaults
//  busy follows the front-to-back queue being full; the back end never holds off
// ----------------------------------------------------------------------------
module spot_light_sample
    import slsmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           i_eye_x,
    input  logic [31:0]           i_eye_y,
    input  logic [31:0]           i_eye_z,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_result_strobe,
    output logic [15:0]           o_dir_x,
    output logic [15:0]           o_dir_y,
    output logic [15:0]           o_dir_z,
    output logic [31:0]           o_radiance_r,
    output logic [31:0]           o_radiance_g,
    output logic [31:0]           o_radiance_b,
    output logic                  o_sample_pdf,
    output logic                  o_degenerate
);

    logic [2:0][31:0] r_lp;
    t_cfg             r_cfg;
    logic             push;
    t_item            f_item;
    logic             qfull;
    logic             q_vld;
    t_item            q_item;
    logic             res_vld;
    t_res             res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp            <= '0;
            r_cfg.axis      <= AXIS_RST;
            r_cfg.cos_outer <= COS_OUTER_RST;
            r_cfg.cos_inner <= COS_INNER_RST;
            r_cfg.intensity <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIGHT_POS_X: r_lp[0]         <= i_cfg_data[31:0];
                REG_LIGHT_POS_Y: r_lp[1]         <= i_cfg_data[31:0];
                REG_LIGHT_POS_Z: r_lp[2]         <= i_cfg_data[31:0];
                REG_AXIS:        r_cfg.axis      <= i_cfg_data;
                REG_COS_OUTER:   r_cfg.cos_outer <= i_cfg_data[15:0];
                REG_COS_INNER:   r_cfg.cos_inner <= i_cfg_data[15:0];
                REG_INTENSITY:   r_cfg.intensity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    slsmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_eye   ({i_eye_z, i_eye_y, i_eye_x}),
        .i_lp    (r_lp),
        .i_qfull (qfull),
        .o_busy  (busy),
        .o_push  (push),
        .o_item  (f_item)
    );

    slsmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (qfull),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    slsmp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (q_vld),
        .i_item    (q_item),
        .i_cfg     (r_cfg),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    assign o_result_strobe = res_vld;
    assign o_dir_x         = res.dir[0];
    assign o_dir_y         = res.dir[1];
    assign o_dir_z         = res.dir[2];
    assign o_radiance_r    = res.rad[0];
    assign o_radiance_g    = res.rad[1];
    assign o_radiance_b    = res.rad[2];
    assign o_sample_pdf    = 1'b1;
    assign o_degenerate    = res.degen;

endmodule

FILE: rtl/slsmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsmp_checker
// Port-level checks on the spot light sample block, bound to the top level.
// ----------------------------------------------------------------------------
module slsmp_checker
    import slsmp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  busy,
    input logic                  o_result_strobe,
    input logic [15:0]           o_dir_x,
    input logic [15:0]           o_dir_y,
    input logic [15:0]           o_dir_z,
    input logic [31:0]           o_radiance_r,
    input logic [31:0]           o_radiance_g,
    input logic [31:0]           o_radiance_b,
    input logic                  o_sample_pdf,
    input logic                  o_degenerate
);

    // reset leaves no result pending and the block open for requests
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_result_strobe && !busy))
        else $error("result or busy right after reset");

    a_pdf_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_sample_pdf)
        else $error("pdf not one");

    // coincident point gives a zero direction and zero radiance
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_degenerate) |->
            (o_dir_x == 16'd0 && o_dir_y == 16'd0 && o_dir_z == 16'd0 &&
             o_radiance_r == 32'd0 && o_radiance_g == 32'd0 && o_radiance_b == 32'd0))
        else $error("degenerate result not zero");

    // direction components stay within the unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_degenerate) |->
            ($signed(o_dir_x) <= 16384 && $signed(o_dir_x) >= -16384 &&
             $signed(o_dir_y) <= 16384 && $signed(o_dir_y) >= -16384 &&
             $signed(o_dir_z) <= 16384 && $signed(o_dir_z) >= -16384))
        else $error("direction component out of range");

endmodule

bind spot_light_sample slsmp_checker u_slsmp_checker (.*);
